/* design/scm_pkg.sv */
`default_nettype none
package scm_pkg;

  localparam int unsigned CUM_BITS       = 14;
  localparam int unsigned CFG_IDX_BITS   = 2;
  localparam int unsigned CFG_DATA_BITS  = 7;
  localparam int unsigned POS_BITS       = 6;
  localparam int unsigned ENERGY_IN_BITS = 8;

  localparam logic [CUM_BITS-1:0]      CUM_MAX   = '1;
  localparam logic [CFG_DATA_BITS-1:0] DIM_RESET = 7'd64;

  localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DIR    = 2'd2;

  typedef logic [CUM_BITS-1:0] cum_t;

  // which upper neighbours take part in a table cell
  typedef struct packed {
    logic left_ok;
    logic right_ok;
    logic first_line;
  } nbr_t;

endpackage
`default_nettype wire

/* design/seam_carving_min_seam.sv */
`default_nettype none
// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+-----------------------------------
// pixel in  | in        | start high, busy low       | energy_i
// seam out  | out       | result_valid_o, one cycle  | seam_position_o, line_number_o, last_o
// config    | in        | cfg_valid_i & cfg_ready_o  | cfg_index_i, cfg_data_i
//
// Loading takes one cycle per pixel. The beat that completes the image starts the table
// build, one table cell per cycle through the one read and one write port of the
// cumulative memory. The backtrack then reads three neighbours per line over that same
// read port, one line at a time. busy stays high from the completing beat until the last
// result. Reset clears control and sets the configuration to its defaults; the memories
// need no clearing pass. The receiver cannot stall: each result shows for exactly one cycle.
module seam_carving_min_seam
  import scm_pkg::*;
#(
  parameter int unsigned MAX_DIM     = 64,
  parameter int unsigned ENERGY_BITS = 8
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [ENERGY_IN_BITS-1:0] energy_i,
  output logic                           result_valid_o,
  output logic [POS_BITS-1:0]            seam_position_o,
  output logic [POS_BITS-1:0]            line_number_o,
  output logic                           last_o,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [CFG_IDX_BITS-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data_i
);

  localparam int unsigned DW    = $clog2(MAX_DIM + 1);
  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned PW    = 2 * DW + 1;
  localparam int unsigned EW    = (ENERGY_BITS < ENERGY_IN_BITS) ? ENERGY_BITS : ENERGY_IN_BITS;

  typedef enum logic [1:0] {ST_LOAD, ST_BUILD, ST_TRACE} state_e;
  typedef enum logic [1:0] {TR_MID, TR_LEFT, TR_RIGHT, TR_PICK} trace_e;

  function automatic logic [DW-1:0] clamp_dim(input logic [CFG_DATA_BITS-1:0] v);
    logic [DW-1:0] r;
    if (v < CFG_DATA_BITS'(2)) begin
      r = DW'(2);
    end else if (v > CFG_DATA_BITS'(MAX_DIM)) begin
      r = DW'(MAX_DIM);
    end else begin
      r = DW'(v);
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] cell_idx(input logic [DW-1:0] ln,
                                             input logic [DW-1:0] pos,
                                             input logic [DW-1:0] w,
                                             input logic          horiz);
    logic [PW-1:0] t;
    if (horiz) begin
      t = PW'(pos) * PW'(w) + PW'(ln);
    end else begin
      t = PW'(ln) * PW'(w) + PW'(pos);
    end
    return t[AW-1:0];
  endfunction

  // configuration
  logic [CFG_DATA_BITS-1:0] width_q, height_q;
  logic                     dir_q;

  // control
  state_e        state_q;
  trace_e        tr_q;
  logic [AW-1:0] cnt_q;
  logic [DW-1:0] line_q, scan_q;
  logic          a_done_q;
  logic          bv_q;
  logic [DW-1:0] bj_q, bline_q;
  cum_t          wl_q, wm_q, best_q, tbest_q;
  logic [EW-1:0] eh_q;
  logic [DW-1:0] bp_q, cur_q, tline_q, tbp_q;

  // results
  logic                rv_q, last_q;
  logic [POS_BITS-1:0] pos_q, lnum_q;

  // memories
  logic [EW-1:0] emem [DEPTH];
  cum_t          cmem [DEPTH];
  logic [EW-1:0] e_rdata_q;
  cum_t          c_rdata_q;

  logic [DW-1:0] w_dim, h_dim, lines, npos;
  logic [PW-1:0] total;
  logic          pix_acc, pix_last;
  logic          a_act;
  logic [DW-1:0] a_pos, a_prev;
  logic [DW-1:0] t_pos, t_final;
  logic          t_right_ok;
  logic [AW-1:0] c_raddr, e_raddr, c_waddr;
  logic          c_we;
  logic [DW-1:0] b_cell;
  logic          b_last_line, b_better, fin;
  logic [DW-1:0] fin_pos;
  nbr_t          nbr;
  cum_t          cell_sum;

  always_comb begin
    w_dim    = clamp_dim(width_q);
    h_dim    = clamp_dim(height_q);
    lines    = dir_q ? w_dim : h_dim;
    npos     = dir_q ? h_dim : w_dim;
    total    = PW'(w_dim) * PW'(h_dim);
    pix_acc  = start && !busy;
    pix_last = (PW'(cnt_q) + PW'(1)) >= total;

    // table build, issue side
    a_act  = (state_q == ST_BUILD) && !a_done_q;
    a_pos  = (scan_q == npos) ? (npos - DW'(1)) : scan_q;
    a_prev = (line_q == '0) ? '0 : (line_q - DW'(1));

    // backtrack neighbour address
    t_right_ok = cur_q < (npos - DW'(1));
    unique case (tr_q)
      TR_LEFT:  t_pos = (cur_q == '0) ? cur_q : (cur_q - DW'(1));
      TR_RIGHT: t_pos = t_right_ok ? (cur_q + DW'(1)) : cur_q;
      default:  t_pos = cur_q;
    endcase
    t_final = (t_right_ok && (c_rdata_q < tbest_q)) ? (cur_q + DW'(1)) : tbp_q;

    c_raddr = (state_q == ST_TRACE) ? cell_idx(tline_q, t_pos, w_dim, dir_q)
                                    : cell_idx(a_prev, a_pos, w_dim, dir_q);
    e_raddr = cell_idx(line_q, a_pos, w_dim, dir_q);

    // table build, data side: cell bj-1 of line bline
    b_cell         = bj_q - DW'(1);
    c_we           = bv_q && (bj_q != '0);
    c_waddr        = cell_idx(bline_q, b_cell, w_dim, dir_q);
    nbr.left_ok    = bj_q > DW'(1);
    nbr.right_ok   = bj_q < npos;
    nbr.first_line = bline_q == '0;
    b_last_line    = bline_q == (lines - DW'(1));
    b_better       = (b_cell == '0) || (cell_sum < best_q);
    fin            = bv_q && (bj_q == npos) && b_last_line;
    fin_pos        = (cell_sum < best_q) ? b_cell : bp_q;
  end

  scm_cell #(
    .EW(EW)
  ) u_cell (
    .left_i  (wl_q),
    .mid_i   (wm_q),
    .right_i (c_rdata_q),
    .nbr_i   (nbr),
    .energy_i(eh_q),
    .sum_o   (cell_sum)
  );

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      emem[cnt_q] <= energy_i[EW-1:0];
    end
    e_rdata_q <= emem[e_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (c_we) begin
      cmem[c_waddr] <= cell_sum;
    end
    c_rdata_q <= cmem[c_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_RESET;
      height_q <= DIM_RESET;
      dir_q    <= 1'b0;
      state_q  <= ST_LOAD;
      tr_q     <= TR_MID;
      cnt_q    <= '0;
      line_q   <= '0;
      scan_q   <= '0;
      a_done_q <= 1'b0;
      bv_q     <= 1'b0;
      bj_q     <= '0;
      bline_q  <= '0;
      wl_q     <= '0;
      wm_q     <= '0;
      eh_q     <= '0;
      best_q   <= '0;
      bp_q     <= '0;
      cur_q    <= '0;
      tline_q  <= '0;
      tbest_q  <= '0;
      tbp_q    <= '0;
      rv_q     <= 1'b0;
      last_q   <= 1'b0;
      pos_q    <= '0;
      lnum_q   <= '0;
    end else begin
      // result beat on the far-line pick and on every backtrack pick
      rv_q <= fin || ((state_q == ST_TRACE) && (tr_q == TR_PICK));

      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_WIDTH:  width_q  <= cfg_data_i;
          CFG_HEIGHT: height_q <= cfg_data_i;
          CFG_DIR:    dir_q    <= cfg_data_i[0];
          default:    ;
        endcase
      end

      // build pipeline registers bv, bj and bline advance every cycle; the window registers only on a valid cell
      bv_q    <= a_act;
      bj_q    <= scan_q;
      bline_q <= line_q;
      if (bv_q) begin
        wl_q <= wm_q;
        wm_q <= c_rdata_q;
        eh_q <= e_rdata_q;
      end
      if (c_we && b_last_line && b_better) begin
        best_q <= cell_sum;
        bp_q   <= b_cell;
      end

      unique case (state_q)
        ST_LOAD: begin
          if (pix_acc) begin
            if (pix_last) begin
              cnt_q    <= '0;
              line_q   <= '0;
              scan_q   <= '0;
              a_done_q <= 1'b0;
              state_q  <= ST_BUILD;
            end else begin
              cnt_q <= cnt_q + AW'(1);
            end
          end
        end
        ST_BUILD: begin
          if (a_act) begin
            if (scan_q == npos) begin
              scan_q <= '0;
              if (line_q == (lines - DW'(1))) begin
                a_done_q <= 1'b1;
              end else begin
                line_q <= line_q + DW'(1);
              end
            end else begin
              scan_q <= scan_q + DW'(1);
            end
          end
          if (fin) begin
            // far line done: emit its minimum and start the backtrack
            pos_q   <= POS_BITS'(fin_pos);
            lnum_q  <= POS_BITS'(lines - DW'(1));
            last_q  <= 1'b0;
            cur_q   <= fin_pos;
            tline_q <= lines - DW'(2);
            tr_q    <= TR_MID;
            state_q <= ST_TRACE;
          end
        end
        ST_TRACE: begin
          unique case (tr_q)
            TR_MID: begin
              tr_q <= TR_LEFT;
            end
            TR_LEFT: begin
              tbest_q <= c_rdata_q;
              tbp_q   <= cur_q;
              tr_q    <= TR_RIGHT;
            end
            TR_RIGHT: begin
              if ((cur_q != '0) && (c_rdata_q < tbest_q)) begin
                tbest_q <= c_rdata_q;
                tbp_q   <= cur_q - DW'(1);
              end
              tr_q <= TR_PICK;
            end
            TR_PICK: begin
              pos_q  <= POS_BITS'(t_final);
              lnum_q <= POS_BITS'(tline_q);
              last_q <= tline_q == '0;
              cur_q  <= t_final;
              tr_q   <= TR_MID;
              if (tline_q == '0) begin
                state_q <= ST_LOAD;
              end else begin
                tline_q <= tline_q - DW'(1);
              end
            end
            default: tr_q <= TR_MID;
          endcase
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  assign busy            = state_q != ST_LOAD;
  assign cfg_ready_o     = !busy;
  assign result_valid_o  = rv_q;
  assign seam_position_o = pos_q;
  assign line_number_o   = lnum_q;
  assign last_o          = last_q;

  a_result_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q |-> $past(busy))
    else $error("result beat outside a run");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rv_q && last_q) |-> !busy)
    else $error("run did not end on the last beat");

  a_build_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bv_q |-> (state_q == ST_BUILD))
    else $error("table cell written outside the build");

  a_trace_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_TRACE) |-> (tr_q == TR_MID))
    else $error("backtrack step left mid-line");

endmodule
`default_nettype wire

/* design/scm_cell.sv */
`default_nettype none
module scm_cell
  import scm_pkg::*;
#(
  parameter int unsigned EW = 8
) (
  input  cum_t          left_i,
  input  cum_t          mid_i,
  input  cum_t          right_i,
  input  nbr_t          nbr_i,
  input  logic [EW-1:0] energy_i,
  output cum_t          sum_o
);

  localparam int unsigned SW = CUM_BITS + 1;

  cum_t          best;
  logic [SW-1:0] total;

  always_comb begin
    best = mid_i;
    if (nbr_i.left_ok && (left_i < best)) begin
      best = left_i;
    end
    if (nbr_i.right_ok && (right_i < best)) begin
      best = right_i;
    end
    if (nbr_i.first_line) begin
      best = '0;
    end
    total = SW'(best) + SW'(energy_i);
    // saturate at the top of the table range
    sum_o = (total > SW'(CUM_MAX)) ? CUM_MAX : total[CUM_BITS-1:0];
  end

endmodule
`default_nettype wire
